/* sv/swcd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package swcd_pkg;

  // Fixed widths of the item fields and the registers.
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned MINHIGH_W = 7;
  localparam int unsigned COUNT_W   = 32;

  // Default window length.
  localparam int unsigned WINDOW_LEN_DEF = 5;

  // Register file: four registers at byte addresses 0, 4, 8 and 12.
  localparam int unsigned APB_AW = 4;
  localparam int unsigned APB_DW = 32;

  localparam logic [1:0] REG_HIGH_THR = 2'd0;
  localparam logic [1:0] REG_MAX_THR  = 2'd1;
  localparam logic [1:0] REG_AVG_THR  = 2'd2;
  localparam logic [1:0] REG_MIN_HIGH = 2'd3;

  // Reset values of the registers.
  localparam logic signed [SAMPLE_W-1:0] HIGH_THR_RST = 16'sd100;
  localparam logic signed [SAMPLE_W-1:0] MAX_THR_RST  = 16'sd150;
  localparam logic signed [SAMPLE_W-1:0] AVG_THR_RST  = 16'sd90;
  localparam logic [MINHIGH_W-1:0]       MIN_HIGH_RST = 7'd3;

  // One input item.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] reading;
    logic                       last;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic               window_full;
    logic               window_critical;
    logic [COUNT_W-1:0] critical_count;
    logic               sequence_done;
  } out_item_t;

  // All configuration registers.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] high_thr;
    logic signed [SAMPLE_W-1:0] max_thr;
    logic signed [SAMPLE_W-1:0] avg_thr;
    logic [MINHIGH_W-1:0]       min_high;
  } cfg_t;

  // Thresholds that every cell compares its sample against.
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] high_thr;
    logic signed [SAMPLE_W-1:0] max_thr;
  } thr_t;

endpackage

`default_nettype wire

/* sv/swcd_cell.sv */
`timescale 1ns / 1ps
`default_nettype none

module swcd_cell #(
  parameter int unsigned CNT_W = 3
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 shift_i,
  input  wire logic                                 clear_i,
  input  wire logic signed [swcd_pkg::SAMPLE_W-1:0] sample_i,
  input  wire logic                                 valid_i,
  input  wire swcd_pkg::thr_t                       thr_i,
  input  wire logic [CNT_W-1:0]                     hacc_i,
  input  wire logic [CNT_W-1:0]                     eacc_i,
  output logic signed [swcd_pkg::SAMPLE_W-1:0]      sample_o,
  output logic                                      valid_o,
  output logic                                      hi_o,
  output logic                                      ex_o,
  output logic [CNT_W-1:0]                          hacc_o,
  output logic [CNT_W-1:0]                          eacc_o
);

  import swcd_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       valid_q;
  logic [CNT_W-1:0]           hacc_q;
  logic [CNT_W-1:0]           eacc_q;

  // Sample slot: takes the neighbor's sample whenever the window moves.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      sample_q <= sample_i;
    end
  end

  // Occupancy of the slot; a finished sequence empties the whole row.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (clear_i) begin
      valid_q <= 1'b0;
    end else if (shift_i) begin
      valid_q <= valid_i;
    end
  end

  // Flags of the stored sample against the current thresholds.
  assign hi_o = valid_q && (sample_q >= thr_i.high_thr);
  assign ex_o = valid_q && (sample_q > thr_i.max_thr);

  // Running tallies that ripple down the row one cell per cycle. Once the
  // tallies have rippled through every cell of a still row, the last cell
  // holds the full high and excess counts.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hacc_q <= '0;
      eacc_q <= '0;
    end else begin
      hacc_q <= hacc_i + CNT_W'(hi_o);
      eacc_q <= eacc_i + CNT_W'(ex_o);
    end
  end

  assign sample_o = sample_q;
  assign valid_o  = valid_q;
  assign hacc_o   = hacc_q;
  assign eacc_o   = eacc_q;

endmodule

`default_nettype wire

/* sv/swcd_cfg.sv */
`timescale 1ns / 1ps
`default_nettype none

module swcd_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [swcd_pkg::APB_AW-1:0]    paddr,
  input  wire logic [swcd_pkg::APB_DW-1:0]    pwdata,
  output logic [swcd_pkg::APB_DW-1:0]         prdata,
  output logic                                pready,
  output swcd_pkg::cfg_t                      cfg_o,
  output logic                                wr_o
);

  import swcd_pkg::*;

  cfg_t       cfg_q;
  logic       wr;
  logic [1:0] idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr     = psel && penable && pwrite && pready;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_thr <= HIGH_THR_RST;
      cfg_q.max_thr  <= MAX_THR_RST;
      cfg_q.avg_thr  <= AVG_THR_RST;
      cfg_q.min_high <= MIN_HIGH_RST;
    end else if (wr) begin
      unique case (idx)
        REG_HIGH_THR: cfg_q.high_thr <= pwdata[SAMPLE_W-1:0];
        REG_MAX_THR:  cfg_q.max_thr  <= pwdata[SAMPLE_W-1:0];
        REG_AVG_THR:  cfg_q.avg_thr  <= pwdata[SAMPLE_W-1:0];
        REG_MIN_HIGH: cfg_q.min_high <= pwdata[MINHIGH_W-1:0];
        default:      cfg_q.min_high <= cfg_q.min_high;
      endcase
    end
  end

  // Register reads; the signed thresholds come back sign extended and the
  // high count zero extended.
  always_comb begin
    unique case (idx)
      REG_HIGH_THR: prdata = APB_DW'(cfg_q.high_thr);
      REG_MAX_THR:  prdata = APB_DW'(cfg_q.max_thr);
      REG_AVG_THR:  prdata = APB_DW'(cfg_q.avg_thr);
      REG_MIN_HIGH: prdata = APB_DW'(cfg_q.min_high);
      default:      prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;
  assign wr_o  = wr;

endmodule

`default_nettype wire

/* sv/sliding_window_critical_detector_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Sliding-window critical detector. Takes one signed reading per cycle and
// returns one result item per reading in the next cycle, through an output
// register. The last WINDOW_LEN readings sit in a row of cells that shifts on
// every accepted item; the window sum and the high and excess counts are
// kept incrementally, so a new item can enter every cycle. A full window is
// critical when at least min_high_count readings are at or above the high
// limit, none is above the ceiling and the sum is at least the average limit
// times WINDOW_LEN. An item with last set ends the sequence and empties the
// window and the count. The input stalls while a result waits on a stalled
// output. After every register write the counts are rebuilt by letting
// tallies ripple through the row: the input stalls after the write until
// the recount timer has run out.
module sliding_window_critical_detector_unit #(
  parameter int unsigned WINDOW_LEN = swcd_pkg::WINDOW_LEN_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // Input channel.
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire swcd_pkg::in_item_t            in_data_i,
  // Output channel.
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output swcd_pkg::out_item_t                out_data_o,
  // Configuration port.
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [swcd_pkg::APB_AW-1:0]   paddr,
  input  wire logic [swcd_pkg::APB_DW-1:0]   pwdata,
  output logic [swcd_pkg::APB_DW-1:0]        prdata,
  output logic                               pready
);

  import swcd_pkg::*;

  localparam int unsigned CntW = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CmpW = (CntW > MINHIGH_W) ? CntW : MINHIGH_W;
  localparam int unsigned SumW = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int unsigned RcW  = $clog2(WINDOW_LEN + 2);

  cfg_t cfg;
  logic cfg_wr;
  thr_t thr;

  // Configuration registers.
  swcd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .wr_o    (cfg_wr)
  );

  assign thr = {cfg.high_thr, cfg.max_thr};

  // Handshakes.
  logic in_acc;
  logic out_free;
  logic busy;
  logic out_valid_q;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy || !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // Row of window cells.
  logic signed [SAMPLE_W-1:0] cell_smp [WINDOW_LEN];
  logic                       cell_vld [WINDOW_LEN];
  logic                       cell_hi  [WINDOW_LEN];
  logic                       cell_ex  [WINDOW_LEN];
  logic [CntW-1:0]            cell_ha  [WINDOW_LEN];
  logic [CntW-1:0]            cell_ea  [WINDOW_LEN];
  logic                       clear;

  assign clear = in_acc && in_data_i.last;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    if (i == 0) begin : g_head
      swcd_cell #(
        .CNT_W (CntW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (in_acc),
        .clear_i  (clear),
        .sample_i (in_data_i.reading),
        .valid_i  (1'b1),
        .thr_i    (thr),
        .hacc_i   ({CntW{1'b0}}),
        .eacc_i   ({CntW{1'b0}}),
        .sample_o (cell_smp[i]),
        .valid_o  (cell_vld[i]),
        .hi_o     (cell_hi[i]),
        .ex_o     (cell_ex[i]),
        .hacc_o   (cell_ha[i]),
        .eacc_o   (cell_ea[i])
      );
    end else begin : g_body
      swcd_cell #(
        .CNT_W (CntW)
      ) u_cell (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .shift_i  (in_acc),
        .clear_i  (clear),
        .sample_i (cell_smp[i-1]),
        .valid_i  (cell_vld[i-1]),
        .thr_i    (thr),
        .hacc_i   (cell_ha[i-1]),
        .eacc_i   (cell_ea[i-1]),
        .sample_o (cell_smp[i]),
        .valid_o  (cell_vld[i]),
        .hi_o     (cell_hi[i]),
        .ex_o     (cell_ex[i]),
        .hacc_o   (cell_ha[i]),
        .eacc_o   (cell_ea[i])
      );
    end
  end

  // The window is full after this item when the slot feeding the last cell
  // already holds a reading.
  logic full_next;

  if (WINDOW_LEN == 1) begin : g_full_one
    assign full_next = 1'b1;
  end else begin : g_full_row
    assign full_next = cell_vld[WINDOW_LEN-2];
  end

  // Window aggregates.
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        hi_q, hi_d;
  logic [CntW-1:0]        ex_q, ex_d;
  logic [COUNT_W-1:0]     tot_q, tot_d;
  logic [RcW-1:0]         rc_q;
  logic                   new_hi, new_ex;
  logic signed [SumW-1:0] old_smp;
  logic signed [SumW-1:0] avg_n;
  logic                   crit;

  assign busy   = (rc_q != '0);
  assign new_hi = in_data_i.reading >= cfg.high_thr;
  assign new_ex = in_data_i.reading > cfg.max_thr;

  // The reading that drops out of the window, zero while the slot is empty.
  assign old_smp = cell_vld[WINDOW_LEN-1] ? SumW'(cell_smp[WINDOW_LEN-1]) : '0;

  assign sum_d = sum_q + SumW'(in_data_i.reading) - old_smp;
  assign hi_d  = hi_q + CntW'(new_hi) - CntW'(cell_hi[WINDOW_LEN-1]);
  assign ex_d  = ex_q + CntW'(new_ex) - CntW'(cell_ex[WINDOW_LEN-1]);

  // Exact integer form of the average test.
  assign avg_n = SumW'(cfg.avg_thr) * $signed(SumW'(WINDOW_LEN));

  assign crit = full_next
             && (CmpW'(hi_d) >= CmpW'(cfg.min_high))
             && (ex_d == '0)
             && (sum_d >= avg_n);

  assign tot_d = (crit && (tot_q != '1)) ? tot_q + COUNT_W'(1) : tot_q;

  // Aggregate registers: updated per item, cleared at the end of a sequence,
  // and reloaded from the tail of the row once a recount has settled.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      hi_q  <= '0;
      ex_q  <= '0;
      tot_q <= '0;
    end else if (in_acc) begin
      if (in_data_i.last) begin
        sum_q <= '0;
        hi_q  <= '0;
        ex_q  <= '0;
        tot_q <= '0;
      end else begin
        sum_q <= sum_d;
        hi_q  <= hi_d;
        ex_q  <= ex_d;
        tot_q <= tot_d;
      end
    end else if (rc_q == RcW'(1)) begin
      hi_q <= cell_ha[WINDOW_LEN-1];
      ex_q <= cell_ea[WINDOW_LEN-1];
    end
  end

  // Recount timer: a register write restarts it, and the input waits until
  // the tallies have rippled through every cell.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
    end else if (cfg_wr) begin
      rc_q <= RcW'(WINDOW_LEN + 1);
    end else if (rc_q != '0) begin
      rc_q <= rc_q - RcW'(1);
    end
  end

  // Output register.
  out_item_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_q.window_full     <= full_next;
      out_q.window_critical <= crit;
      out_q.critical_count  <= tot_d;
      out_q.sequence_done   <= in_data_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
